FILE: hdl/assert_macros.svh
// Assertion macros used by the RTL of the sliding window sender.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// Property must hold at every clock edge out of reset.
`define ASSERT_PROP(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
		else $error("assertion failed");

// Condition must never be seen at a clock edge out of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	`ASSERT_PROP(label, clk, rst_n, !(cond))

`else

`define ASSERT_PROP(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

FILE: hdl/sws_pkg.sv
// Types and constants of the sliding window sender.
`default_nettype none

package sws_pkg;

	// Sequence space and payload width
	localparam int SEQ_SPACE    = 8;
	localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
	localparam int PAYLOAD_BITS = 32;

	// Window size register
	localparam int                WS_BITS      = 4;
	localparam logic [WS_BITS-1:0] WINDOW_RESET = WS_BITS'(4);

	// Width of base plus window size, before the wrap
	localparam int TOP_BITS = SEQ_BITS + WS_BITS;

	// Duplicate ack count that triggers a fast retransmit
	localparam int            DUP_BITS  = 2;
	localparam logic [DUP_BITS-1:0] DUP_LIMIT = DUP_BITS'(3);

	// Operation codes
	localparam logic [1:0] OP_SEND    = 2'd0;
	localparam logic [1:0] OP_ACK     = 2'd1;
	localparam logic [1:0] OP_TIMEOUT = 2'd2;

	// Timer commands
	localparam logic [1:0] TIMER_LEAVE   = 2'd0;
	localparam logic [1:0] TIMER_STOP    = 2'd1;
	localparam logic [1:0] TIMER_RESTART = 2'd2;

	// Input word
	typedef struct packed {
		logic [1:0]              op;
		logic [PAYLOAD_BITS-1:0] payload;
		logic [SEQ_BITS-1:0]     ack_number;
		logic                    ack_intact;
	} in_word_t;

	// Result word
	typedef struct packed {
		logic                    accepted;
		logic                    xmit_valid;
		logic [SEQ_BITS-1:0]     xmit_seq;
		logic [PAYLOAD_BITS-1:0] xmit_payload;
		logic [1:0]              timer_cmd;
		logic [SEQ_BITS-1:0]     window_base;
		logic [SEQ_BITS-1:0]     next_seq;
	} out_word_t;

endpackage

`default_nettype wire

FILE: hdl/sliding_window_sender.sv
// Go-back-N sender with fast retransmit: window state, packet store, result buffer.
//
//   channel | direction | handshake           | word
//   --------+-----------+---------------------+-------------------------
//   in      | input     | in_valid / in_stall   | in_word  (in_word_t)
//   out     | output    | out_valid / out_stall | out_word (out_word_t)
//   cfg     | input     | cfg_wr_en             | cfg_wr_data (window size)
//
// One word per cycle while in_stall is low: each event is resolved in the cycle it is
// accepted; its result is registered in the output register, or in the skid register.
// A stalled output register is backed by one skid register; in_stall rises only
// while the skid register holds a word.
// Reset clears base, next, duplicate count and the output buffer and loads a
// window size of 4; the packet store is not cleared.
`default_nettype none
`include "assert_macros.svh"

module sliding_window_sender
	import sws_pkg::*;
(
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                cfg_wr_en,
	input  wire logic [WS_BITS-1:0]  cfg_wr_data,
	input  wire logic                in_valid,
	output logic                     in_stall,
	input  wire in_word_t            in_word,
	output logic                     out_valid,
	input  wire logic                out_stall,
	output out_word_t                out_word
);

	logic [WS_BITS-1:0]      ws_q;
	logic [SEQ_BITS-1:0]     base_q, next_q;
	logic [DUP_BITS-1:0]     dup_q;
	logic [PAYLOAD_BITS-1:0] store_q [SEQ_SPACE];

	logic [SEQ_BITS-1:0]     base_d, next_d;
	logic [DUP_BITS-1:0]     dup_d, dup_inc;
	logic [TOP_BITS-1:0]     top;
	logic [TOP_BITS-1:0]     ack_ext;
	logic [SEQ_BITS-1:0]     full_at;
	logic                    in_window;
	logic                    send_ok;
	logic                    accept_in;
	logic                    out_free;
	out_word_t               res;

	logic                    out_valid_q, skid_valid_q;
	out_word_t               out_word_q, skid_word_q;

	assign accept_in = in_valid && !in_stall;
	assign in_stall  = skid_valid_q;
	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;
	assign out_free  = !out_valid_q || !out_stall;

	// Window arithmetic
	assign top     = TOP_BITS'(base_q) + TOP_BITS'(ws_q);
	assign full_at = SEQ_BITS'(top - TOP_BITS'(1));
	assign ack_ext = TOP_BITS'(in_word.ack_number);
	assign dup_inc = dup_q + DUP_BITS'(1);
	assign send_ok = (next_q != full_at);

	always_comb begin
		if (top <= TOP_BITS'(SEQ_SPACE)) begin
			in_window = (ack_ext >= TOP_BITS'(base_q)) && (ack_ext < top);
		end else begin
			in_window = (in_word.ack_number >= base_q) ||
				(in_word.ack_number < top[SEQ_BITS-1:0]);
		end
	end

	// Event resolution
	always_comb begin
		base_d           = base_q;
		next_d           = next_q;
		dup_d            = dup_q;
		res.accepted     = 1'b0;
		res.xmit_valid   = 1'b0;
		res.xmit_seq     = '0;
		res.xmit_payload = '0;
		res.timer_cmd    = TIMER_LEAVE;
		case (in_word.op)
			OP_SEND: begin
				if (send_ok) begin
					res.accepted     = 1'b1;
					res.xmit_valid   = 1'b1;
					res.xmit_seq     = next_q;
					res.xmit_payload = in_word.payload;
					if (base_q == next_q) begin
						res.timer_cmd = TIMER_RESTART;
					end
					next_d = next_q + SEQ_BITS'(1);
				end
			end
			OP_ACK: begin
				if (in_word.ack_intact) begin
					if (in_window) begin
						dup_d  = '0;
						base_d = in_word.ack_number + SEQ_BITS'(1);
						res.timer_cmd = (base_d != next_q) ? TIMER_RESTART : TIMER_STOP;
					end else if (dup_inc == DUP_LIMIT) begin
						// fast retransmit of the base packet
						dup_d            = '0;
						res.timer_cmd    = TIMER_RESTART;
						res.xmit_valid   = 1'b1;
						res.xmit_seq     = base_q;
						res.xmit_payload = store_q[base_q];
					end else begin
						dup_d = dup_inc;
					end
				end
			end
			OP_TIMEOUT: begin
				res.timer_cmd    = TIMER_RESTART;
				res.xmit_valid   = 1'b1;
				res.xmit_seq     = base_q;
				res.xmit_payload = store_q[base_q];
			end
			default: begin
			end
		endcase
		res.window_base = base_d;
		res.next_seq    = next_d;
	end

	// Window size register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ws_q <= WINDOW_RESET;
		end else if (cfg_wr_en) begin
			ws_q <= cfg_wr_data;
		end
	end

	// Window state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			base_q <= '0;
			next_q <= '0;
			dup_q  <= '0;
		end else if (accept_in) begin
			base_q <= base_d;
			next_q <= next_d;
			dup_q  <= dup_d;
		end
	end

	// Packet store, written by accepted sends
	always_ff @(posedge clk) begin
		if (accept_in && in_word.op == OP_SEND && send_ok) begin
			store_q[next_q] <= in_word.payload;
		end
	end

	// Output register and skid register: control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q  <= skid_valid_q || accept_in;
			skid_valid_q <= 1'b0;
		end else if (accept_in) begin
			skid_valid_q <= 1'b1;
		end
	end

	// Output register and skid register: data
	always_ff @(posedge clk) begin
		if (out_free) begin
			out_word_q <= skid_valid_q ? skid_word_q : res;
		end else if (accept_in) begin
			skid_word_q <= res;
		end
	end

	// Checks
	`ASSERT_PROP(a_skid_behind_out, clk, arst_n, skid_valid_q |-> out_valid_q)
	`ASSERT_PROP(a_accept_sends, clk, arst_n,
		(out_valid_q && out_word_q.accepted) |-> out_word_q.xmit_valid)
	`ASSERT_PROP(a_next_advance, clk, arst_n,
		(accept_in && res.accepted) |=> (next_q == SEQ_BITS'($past(next_q) + SEQ_BITS'(1))))
	`ASSERT_NEVER(a_dup_below_limit, clk, arst_n, dup_q == DUP_LIMIT)

endmodule

`default_nettype wire
